// ===== hw/rtl/pbca_pkg.sv =====
`default_nettype none

package pbca_pkg;

	localparam int NUM_DIMS   = 2;
	localparam int COORD_W    = 32;
	localparam int ACC_W      = 48;
	localparam int GAIN_W     = 31;
	localparam int MODE_W     = 2;
	localparam int FORCE_W    = COORD_W + GAIN_W - 16;
	localparam int ALU_W      = COORD_W + 2;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_STEPS  = COORD_W;
	localparam int MUL_STEPS  = GAIN_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int OP_W       = 3;

	localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRAP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REFLECT = 2'd2;
	localparam logic [MODE_W-1:0] MODE_REPULSE = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_MODE_DIM0  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MODE_DIM1  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LOWER_DIM0 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_UPPER_DIM0 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LOWER_DIM1 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_UPPER_DIM1 = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPRING     = 3'd6;

	// operation chosen once the coordinate has been compared with the walls
	localparam logic [OP_W-1:0] OP_PASS    = 3'd0;
	localparam logic [OP_W-1:0] OP_WRAP_LO = 3'd1;
	localparam logic [OP_W-1:0] OP_WRAP_HI = 3'd2;
	localparam logic [OP_W-1:0] OP_REFL_LO = 3'd3;
	localparam logic [OP_W-1:0] OP_REFL_HI = 3'd4;
	localparam logic [OP_W-1:0] OP_REP_LO  = 3'd5;
	localparam logic [OP_W-1:0] OP_REP_HI  = 3'd6;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

	localparam logic [MODE_W-1:0]  RST_MODE  = MODE_WRAP;
	localparam logic [COORD_W-1:0] RST_LOWER = '0;
	localparam logic [COORD_W-1:0] RST_UPPER = COORD_W'(65536);
	localparam logic [GAIN_W-1:0]  RST_GAIN  = GAIN_W'(65536);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ALU_W-1:0]   alu_word_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		coord_t            lower;
		coord_t            upper;
	} axis_cfg_t;

	typedef struct packed {
		alu_word_t a;
		alu_word_t b;
		logic      sub;
	} alu_req_t;

	function automatic alu_word_t sx(input coord_t v);
		sx = {{(ALU_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

	function automatic alu_word_t zx(input logic [COORD_W:0] u);
		zx = {{(ALU_W-COORD_W-1){1'b0}}, u};
	endfunction

	function automatic coord_t sat32(input alu_word_t v);
		logic ovf;
		ovf = (v[ALU_W-1:COORD_W-1] != {(ALU_W-COORD_W+1){1'b0}}) &&
			(v[ALU_W-1:COORD_W-1] != {(ALU_W-COORD_W+1){1'b1}});
		if (!ovf) begin
			sat32 = v[COORD_W-1:0];
		end else if (v[ALU_W-1]) begin
			sat32 = COORD_MIN;
		end else begin
			sat32 = COORD_MAX;
		end
	endfunction

	function automatic coord_t neg_sat(input coord_t v);
		neg_sat = (v == COORD_MIN) ? COORD_MAX : -v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pbca_if.sv =====
`default_nettype none

interface pbca_in_if;
	logic                                valid;
	logic                                ready;
	logic                                start_of_pass;
	logic                                axis;
	logic signed [pbca_pkg::COORD_W-1:0] position;
	logic signed [pbca_pkg::COORD_W-1:0] velocity;

	modport source(output valid, output start_of_pass, output axis, output position,
		output velocity, input ready);
	modport sink(input valid, input start_of_pass, input axis, input position,
		input velocity, output ready);
endinterface

interface pbca_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [pbca_pkg::COORD_W-1:0] new_position;
	logic signed [pbca_pkg::COORD_W-1:0] new_velocity;
	logic signed [pbca_pkg::ACC_W-1:0]   wall_force_total;

	modport source(output valid, output new_position, output new_velocity,
		output wall_force_total, input ready);
	modport sink(input valid, input new_position, input new_velocity,
		input wall_force_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pbca_cfg_regs.sv =====
`default_nettype none

module pbca_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [pbca_pkg::REG_IDX_W-1:0]   wr_index,
	input  wire logic [pbca_pkg::CFG_DATA_W-1:0]  wr_data,
	input  wire logic                             axis_sel,
	output pbca_pkg::axis_cfg_t                   axis_cfg,
	output logic [pbca_pkg::GAIN_W-1:0]           gain
);
	import pbca_pkg::*;

	logic [MODE_W-1:0]  mode_q  [2];
	logic [COORD_W-1:0] lower_q [2];
	logic [COORD_W-1:0] upper_q [2];
	logic [GAIN_W-1:0]  gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q[0]  <= RST_MODE;
			mode_q[1]  <= RST_MODE;
			lower_q[0] <= RST_LOWER;
			lower_q[1] <= RST_LOWER;
			upper_q[0] <= RST_UPPER;
			upper_q[1] <= RST_UPPER;
			gain_q     <= RST_GAIN;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE_DIM0:  mode_q[0]  <= wr_data[MODE_W-1:0];
				REG_MODE_DIM1:  mode_q[1]  <= wr_data[MODE_W-1:0];
				REG_LOWER_DIM0: lower_q[0] <= wr_data[COORD_W-1:0];
				REG_UPPER_DIM0: upper_q[0] <= wr_data[COORD_W-1:0];
				REG_LOWER_DIM1: lower_q[1] <= wr_data[COORD_W-1:0];
				REG_UPPER_DIM1: upper_q[1] <= wr_data[COORD_W-1:0];
				REG_SPRING:     gain_q     <= wr_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		axis_cfg.mode  = mode_q[axis_sel];
		axis_cfg.lower = lower_q[axis_sel];
		axis_cfg.upper = upper_q[axis_sel];
	end

	assign gain = gain_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pbca_alu.sv =====
`default_nettype none

// shared adder/subtractor: differences, restoring remainder steps,
// shift-add multiply steps and the final corrections all go through here
module pbca_alu (
	input  wire pbca_pkg::alu_req_t req,
	output pbca_pkg::alu_word_t     res
);
	import pbca_pkg::*;

	alu_word_t b_eff;

	assign b_eff = req.sub ? ~req.b : req.b;
	assign res   = req.a + b_eff + alu_word_t'(req.sub);

endmodule

`default_nettype wire

// ===== hw/rtl/particle_boundary_condition_apply_unit.sv =====
// Boundary rule for one particle coordinate (wrap, reflect, repulse), Q16.16.
// Requests arrive on item (valid/ready): start_of_pass, axis, position,
// velocity. One result per request leaves on result (valid/ready) with the
// new position, new velocity and the running wall-force total.
// Configuration goes through wr_en/wr_index/wr_data; the user must write it
// only while the unit is idle, as the block itself does not enforce this.
// One request is worked at a time; differences, iteration steps and final
// corrections run through a single 34-bit adder under a small sequencer.
// Wrap outside the box takes 32 remainder steps, repulse outside the box 31
// shift-add multiply steps, anything else no iteration step.
// A new request can be taken the cycle after the result is registered. The
// result sits in an output register: a stalled receiver does not stop the
// next request from being accepted and worked, it only holds it in the last
// step until the register frees.
// Reset (arst_n low) loads the register defaults (wrap, box [0,1), gain 1.0),
// clears the force accumulator and drops result.valid.
`default_nettype none

module particle_boundary_condition_apply_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [pbca_pkg::REG_IDX_W-1:0]   wr_index,
	input  wire logic [pbca_pkg::CFG_DATA_W-1:0]  wr_data,
	pbca_in_if.sink                               item,
	pbca_out_if.source                            result
);
	import pbca_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WIDTH = 3'd1;
	localparam logic [2:0] ST_DEPTH = 3'd2;
	localparam logic [2:0] ST_ITER  = 3'd3;
	localparam logic [2:0] ST_FIX   = 3'd4;

	logic [2:0]         state_q;
	logic [OP_W-1:0]    op_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   acc_q;
	logic               out_valid_q;
	coord_t             x_q;
	coord_t             v_q;
	logic               ax_q;
	logic [COORD_W-1:0] w_q;
	logic [COORD_W-1:0] d_q;
	logic [COORD_W:0]   rem_q;
	logic [COORD_W-1:0] shf_q;
	coord_t             npos_q;
	coord_t             nvel_q;
	logic [ACC_W-1:0]   wft_q;

	axis_cfg_t          ax_cfg;
	logic [GAIN_W-1:0]  gain;
	coord_t             lo;
	coord_t             hi;
	logic               axis_ok;
	logic [OP_W-1:0]    op_sel;
	alu_req_t           alu_req;
	alu_word_t          alu_res;
	logic               accept;
	logic               fix_go;
	logic               is_wrap;
	logic [FORCE_W-1:0] force_w;
	logic               force_big;
	logic [ACC_W-1:0]   acc_sum;
	logic [ACC_W-1:0]   acc_next;
	coord_t             npos;
	coord_t             nvel;

	pbca_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.axis_sel (ax_q),
		.axis_cfg (ax_cfg),
		.gain     (gain)
	);

	pbca_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	assign lo      = ax_cfg.lower;
	assign hi      = ax_cfg.upper;
	assign accept  = item.valid && item.ready;
	assign fix_go  = (state_q == ST_FIX) && (!out_valid_q || result.ready);
	assign is_wrap = (op_q == OP_WRAP_LO) || (op_q == OP_WRAP_HI);
	assign axis_ok = (32'(ax_q) < 32'(NUM_DIMS));

	// product = {rem_q[31:0], shf_q[30:0]} after the multiply; keep bits 16 and up
	assign force_w   = {rem_q[COORD_W-1:0], shf_q[GAIN_W-1:16]};
	assign force_big = (force_w[FORCE_W-1:COORD_W] != '0);

	always_comb begin
		op_sel = OP_PASS;
		if (axis_ok) begin
			case (ax_cfg.mode)
				MODE_WRAP: begin
					if (hi > lo) begin
						if (x_q < lo) begin
							op_sel = OP_WRAP_LO;
						end else if (x_q >= hi) begin
							op_sel = OP_WRAP_HI;
						end
					end
				end
				MODE_REFLECT: begin
					if (x_q < lo) begin
						op_sel = OP_REFL_LO;
					end else if (x_q > hi) begin
						op_sel = OP_REFL_HI;
					end
				end
				MODE_REPULSE: begin
					if (x_q < lo) begin
						op_sel = OP_REP_LO;
					end else if (x_q > hi) begin
						op_sel = OP_REP_HI;
					end
				end
				default: op_sel = OP_PASS;
			endcase
		end
	end

	always_comb begin
		alu_req.a   = '0;
		alu_req.b   = '0;
		alu_req.sub = 1'b0;
		unique case (state_q)
			ST_WIDTH: begin
				alu_req.a   = sx(hi);
				alu_req.b   = sx(lo);
				alu_req.sub = 1'b1;
			end
			ST_DEPTH: begin
				case (op_q) inside
					OP_WRAP_LO, OP_REFL_LO, OP_REP_LO: begin
						alu_req.a   = sx(lo);
						alu_req.b   = sx(x_q);
						alu_req.sub = 1'b1;
					end
					OP_WRAP_HI: begin
						alu_req.a   = sx(x_q);
						alu_req.b   = sx(lo);
						alu_req.sub = 1'b1;
					end
					OP_REFL_HI, OP_REP_HI: begin
						alu_req.a   = sx(x_q);
						alu_req.b   = sx(hi);
						alu_req.sub = 1'b1;
					end
					default: begin
					end
				endcase
			end
			ST_ITER: begin
				if (is_wrap) begin
					// restoring remainder: trial subtract of the box width
					alu_req.a   = zx({rem_q[COORD_W-1:0], shf_q[COORD_W-1]});
					alu_req.b   = zx({1'b0, w_q});
					alu_req.sub = 1'b1;
				end else begin
					alu_req.a = zx({1'b0, rem_q[COORD_W-1:0]});
					alu_req.b = shf_q[0] ? zx({1'b0, d_q}) : '0;
				end
			end
			ST_FIX: begin
				case (op_q)
					OP_WRAP_LO: begin
						alu_req.a   = sx(hi);
						alu_req.b   = zx({1'b0, rem_q[COORD_W-1:0]});
						alu_req.sub = 1'b1;
					end
					OP_WRAP_HI: begin
						alu_req.a = sx(lo);
						alu_req.b = zx({1'b0, rem_q[COORD_W-1:0]});
					end
					OP_REFL_LO: begin
						alu_req.a = sx(lo);
						alu_req.b = zx({1'b0, d_q});
					end
					OP_REFL_HI: begin
						alu_req.a   = sx(hi);
						alu_req.b   = zx({1'b0, d_q});
						alu_req.sub = 1'b1;
					end
					OP_REP_LO: begin
						alu_req.a = sx(v_q);
						alu_req.b = zx({1'b0, force_w[COORD_W-1:0]});
					end
					OP_REP_HI: begin
						alu_req.a   = sx(v_q);
						alu_req.b   = zx({1'b0, force_w[COORD_W-1:0]});
						alu_req.sub = 1'b1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		acc_sum  = acc_q + ACC_W'(force_w);
		acc_next = acc_q;
		npos     = x_q;
		nvel     = v_q;
		case (op_q) inside
			OP_WRAP_LO: npos = (rem_q == '0) ? lo : alu_res[COORD_W-1:0];
			OP_WRAP_HI: npos = alu_res[COORD_W-1:0];
			OP_REFL_LO, OP_REFL_HI: begin
				npos = sat32(alu_res);
				nvel = neg_sat(v_q);
			end
			OP_REP_LO: begin
				nvel     = force_big ? COORD_MAX : sat32(alu_res);
				acc_next = acc_sum[ACC_W-1] ? ACC_MAX : acc_sum;
			end
			OP_REP_HI: begin
				nvel     = force_big ? COORD_MIN : sat32(alu_res);
				acc_next = acc_sum[ACC_W-1] ? ACC_MAX : acc_sum;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_PASS;
			cnt_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fix_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WIDTH;
						if (item.start_of_pass) begin
							acc_q <= '0;
						end
					end
				end
				ST_WIDTH: begin
					op_q    <= op_sel;
					state_q <= ST_DEPTH;
				end
				ST_DEPTH: begin
					case (op_q) inside
						OP_WRAP_LO, OP_WRAP_HI: begin
							cnt_q   <= CNT_W'(DIV_STEPS - 1);
							state_q <= ST_ITER;
						end
						OP_REP_LO, OP_REP_HI: begin
							cnt_q   <= CNT_W'(MUL_STEPS - 1);
							state_q <= ST_ITER;
						end
						default: state_q <= ST_FIX;
					endcase
				end
				ST_ITER: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (fix_go) begin
						acc_q   <= acc_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q  <= item.position;
			v_q  <= item.velocity;
			ax_q <= item.axis;
		end
		if (state_q == ST_WIDTH) begin
			w_q <= alu_res[COORD_W-1:0];
		end
		if (state_q == ST_DEPTH) begin
			d_q   <= alu_res[COORD_W-1:0];
			rem_q <= '0;
			if (is_wrap) begin
				shf_q <= alu_res[COORD_W-1:0];
			end else begin
				shf_q <= {{(COORD_W-GAIN_W){1'b0}}, gain};
			end
		end
		if (state_q == ST_ITER) begin
			if (is_wrap) begin
				rem_q <= alu_res[ALU_W-1] ? {rem_q[COORD_W-1:0], shf_q[COORD_W-1]}
					: alu_res[COORD_W:0];
				shf_q <= {shf_q[COORD_W-2:0], 1'b0};
			end else begin
				rem_q <= {1'b0, alu_res[COORD_W:1]};
				shf_q <= {1'b0, alu_res[0], shf_q[GAIN_W-1:1]};
			end
		end
		if (fix_go) begin
			npos_q <= npos;
			nvel_q <= nvel;
			wft_q  <= acc_next;
		end
	end

	assign item.ready              = (state_q == ST_IDLE);
	assign result.valid            = out_valid_q;
	assign result.new_position     = npos_q;
	assign result.new_velocity     = nvel_q;
	assign result.wall_force_total = wft_q;

`ifndef ASSERT_OFF
	a_acc_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_q[ACC_W-1])
		else $error("force accumulator went negative");

	a_rem_below_width: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER) && is_wrap |-> (rem_q < {1'b0, w_q}))
		else $error("partial remainder not below box width");

	a_depth_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEPTH) && (op_q != OP_PASS) |-> !alu_res[ALU_W-1])
		else $error("penetration depth negative");

	a_iter_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER) |-> is_wrap || (op_q == OP_REP_LO) || (op_q == OP_REP_HI))
		else $error("iteration entered for an operation that needs none");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_WIDTH))
		else $error("accepted request did not start the sequence");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pbca_pkg::*;

	localparam longint COORD_HI = 64'sd2147483647;
	localparam longint COORD_LO = -64'sd2147483648;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int DIRECTED_DRAIN = 40;

	typedef struct packed {
		coord_t            new_position;
		coord_t            new_velocity;
		logic [ACC_W-1:0]  wall_force_total;
	} moved_coord_t;

	function automatic longint clamp32(longint v);
		if (v > COORD_HI) begin
			return COORD_HI;
		end
		if (v < COORD_LO) begin
			return COORD_LO;
		end
		return v;
	endfunction

	// Mirror of the boundary unit: box registers, wall-force total, and the
	// moved coordinates still owed by the block.
	class coord_scoreboard;
		logic [MODE_W-1:0] mode [NUM_DIMS];
		longint            lower [NUM_DIMS];
		longint            upper [NUM_DIMS];
		longint unsigned   gain;
		longint unsigned   wall_force;
		moved_coord_t      moved_q [$];
		int errors;
		int n_wrapped;
		int n_reflected;
		int n_repulsed;
		int n_unchanged;
		int n_writes;

		function new();
			for (int i = 0; i < NUM_DIMS; i++) begin
				mode[i] = RST_MODE;
				lower[i] = coord_t'(RST_LOWER);
				upper[i] = coord_t'(RST_UPPER);
			end
			gain = RST_GAIN;
			wall_force = 0;
		endfunction

		function void note_config(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			n_writes++;
			case (idx)
				REG_MODE_DIM0:  mode[0] = data[MODE_W-1:0];
				REG_MODE_DIM1:  mode[1] = data[MODE_W-1:0];
				REG_LOWER_DIM0: lower[0] = coord_t'(data);
				REG_UPPER_DIM0: upper[0] = coord_t'(data);
				REG_LOWER_DIM1: lower[1] = coord_t'(data);
				REG_UPPER_DIM1: upper[1] = coord_t'(data);
				REG_SPRING:     gain = data[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		function void add_wall_force(longint unsigned f);
			wall_force = wall_force + f;
			if (wall_force > ACC_MAX) begin
				wall_force = ACC_MAX;
			end
		endfunction

		function void note_request(bit sp, bit ax, coord_t pos, coord_t vel);
			longint x, v, nx, nv, lo, hi;
			longint unsigned w, r, f;
			bit hit;
			moved_coord_t m;
			x = pos;
			v = vel;
			nx = x;
			nv = v;
			hit = 0;
			if (sp) begin
				wall_force = 0;
			end
			if (ax < NUM_DIMS) begin
				lo = lower[ax];
				hi = upper[ax];
				case (mode[ax])
					MODE_WRAP: begin
						// empty box leaves the coordinate alone
						if (hi > lo) begin
							w = hi - lo;
							if (x < lo) begin
								r = lo - x;
								r = r % w;
								nx = (r == 0) ? lo : hi - longint'(r);
								hit = 1;
							end else if (x >= hi) begin
								r = x - lo;
								r = r % w;
								nx = lo + longint'(r);
								hit = 1;
							end
						end
						n_wrapped += hit;
					end
					MODE_REFLECT: begin
						if (x < lo) begin
							nx = clamp32(2 * lo - x);
							nv = clamp32(-v);
							hit = 1;
						end else if (x > hi) begin
							nx = clamp32(2 * hi - x);
							nv = clamp32(-v);
							hit = 1;
						end
						n_reflected += hit;
					end
					MODE_REPULSE: begin
						if (x < lo) begin
							f = lo - x;
							f = (gain * f) >> 16;
							nv = clamp32(v + longint'(f));
							add_wall_force(f);
							hit = 1;
						end else if (x > hi) begin
							f = x - hi;
							f = (gain * f) >> 16;
							nv = clamp32(v - longint'(f));
							add_wall_force(f);
							hit = 1;
						end
						n_repulsed += hit;
					end
					default: ;
				endcase
			end
			if (!hit) begin
				n_unchanged++;
			end
			m.new_position = nx[COORD_W-1:0];
			m.new_velocity = nv[COORD_W-1:0];
			m.wall_force_total = wall_force[ACC_W-1:0];
			moved_q = {moved_q, m};
		endfunction

		function void check_result(coord_t pos, coord_t vel, logic [ACC_W-1:0] total);
			moved_coord_t m;
			if (moved_q.size() == 0) begin
				$error("result with no request outstanding: new_position %0d", pos);
				errors++;
				return;
			end
			m = moved_q.pop_front();
			if (pos !== m.new_position) begin
				$error("new_position: expected %0d, got %0d", m.new_position, pos);
				errors++;
			end
			if (vel !== m.new_velocity) begin
				$error("new_velocity: expected %0d, got %0d", m.new_velocity, vel);
				errors++;
			end
			if (total !== m.wall_force_total) begin
				$error("wall_force_total: expected %0d, got %0d", m.wall_force_total, total);
				errors++;
			end
		endfunction

		function int pending();
			return moved_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	bit calm;
	int unsigned cycle_count = 0;

	coord_scoreboard sb = new();

	pbca_in_if  item_bus ();
	pbca_out_if result_bus ();

	particle_boundary_condition_apply_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_bus),
		.result   (result_bus)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending());
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_bus.valid && item_bus.ready) begin
				sb.note_request(item_bus.start_of_pass, item_bus.axis,
					item_bus.position, item_bus.velocity);
			end
			if (result_bus.valid && result_bus.ready) begin
				sb.check_result(result_bus.new_position, result_bus.new_velocity,
					result_bus.wall_force_total);
			end
		end
	end

	// result receiver: stall bursts, none once calm
	initial begin
		result_bus.ready = 1'b0;
		forever begin
			if (!calm && $urandom_range(0, 15) == 0) begin
				repeat ($urandom_range(1, 16)) @(negedge clk) result_bus.ready <= 1'b0;
			end else begin
				@(negedge clk) result_bus.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk) wr_en <= 1'b0;
		sb.note_config(idx, data);
	endtask

	task automatic program_axis(bit ax, logic [MODE_W-1:0] md, longint lo, longint hi);
		write_reg(ax ? REG_MODE_DIM1 : REG_MODE_DIM0, CFG_DATA_W'(md));
		write_reg(ax ? REG_LOWER_DIM1 : REG_LOWER_DIM0, lo[CFG_DATA_W-1:0]);
		write_reg(ax ? REG_UPPER_DIM1 : REG_UPPER_DIM0, hi[CFG_DATA_W-1:0]);
	endtask

	task automatic send_coord(bit sp, bit ax, coord_t pos, coord_t vel);
		if (!calm && $urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 16)) @(negedge clk) item_bus.valid <= 1'b0;
		end
		@(negedge clk);
		item_bus.valid <= 1'b1;
		item_bus.start_of_pass <= sp;
		item_bus.axis <= ax;
		item_bus.position <= pos;
		item_bus.velocity <= vel;
		do @(posedge clk); while (!(item_bus.valid && item_bus.ready));
	endtask

	// drop valid and let every owed result come back before touching registers
	task automatic finish_phase();
		@(negedge clk) item_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic coord_t pick_position(longint lo, longint hi);
		longint w, p;
		longint unsigned u, span;
		w = hi - lo;
		u = $urandom;
		case ($urandom_range(0, 9))
			0: p = lo;
			1: p = hi;
			2: p = lo - $urandom_range(1, 70000);
			3: p = hi + $urandom_range(1, 70000);
			4: begin
				span = (w > 0) ? w : 1;
				p = lo + longint'(u % span);
			end
			5: begin
				// exact multiples of the box width land on a zero remainder
				if (w > 0) begin
					p = $urandom_range(0, 1) ? lo + w * $urandom_range(1, 3) :
						lo - w * $urandom_range(1, 3);
				end else begin
					p = lo;
				end
			end
			8: p = $urandom_range(0, 1) ? COORD_HI : COORD_LO;
			9: p = hi - 1;
			default: p = coord_t'(u[31:0]);
		endcase
		p = clamp32(p);
		return p[COORD_W-1:0];
	endfunction

	function automatic coord_t pick_velocity();
		case ($urandom_range(0, 7))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3, 4: return coord_t'($urandom_range(0, 2000)) - 1000;
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic program_random_box();
		longint lo, hi;
		logic [GAIN_W-1:0] g;
		for (int ax = 0; ax < NUM_DIMS; ax++) begin
			case ($urandom_range(0, 5))
				0: begin
					lo = $urandom_range(0, 2097152);
					lo = lo - 1048576;
					hi = lo + $urandom_range(1, 16);
				end
				1: begin
					lo = $urandom_range(0, 33554432);
					lo = lo - 16777216;
					hi = lo + $urandom_range(65536, 4194304);
				end
				2: begin
					lo = COORD_LO;
					hi = COORD_HI;
				end
				3: begin
					lo = coord_t'($urandom);
					hi = coord_t'($urandom);
				end
				4: begin
					lo = $urandom_range(0, 2000000);
					lo = lo - 1000000;
					hi = lo - $urandom_range(0, 1000);
				end
				default: begin
					lo = 0;
					hi = 65536 * $urandom_range(1, 64);
				end
			endcase
			program_axis(ax[0], MODE_W'($urandom_range(0, 3)), lo, hi);
		end
		case ($urandom_range(0, 3))
			0: g = '0;
			1: g = '1;
			2: g = GAIN_W'($urandom_range(0, 131072));
			default: g = GAIN_W'($urandom);
		endcase
		write_reg(REG_SPRING, CFG_DATA_W'(g));
	endtask

	task automatic run_random(int count);
		bit ax;
		for (int i = 0; i < count; i++) begin
			ax = $urandom_range(0, 1);
			send_coord($urandom_range(0, 7) == 0, ax,
				pick_position(sb.lower[ax], sb.upper[ax]), pick_velocity());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		item_bus.valid = 1'b0;
		item_bus.start_of_pass = 1'b0;
		item_bus.axis = 1'b0;
		item_bus.position = '0;
		item_bus.velocity = '0;
		calm = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset box: wrap into [0, 1.0) on both axes
		send_coord(1, 0, 32'sh0000_8000, 32'sh0001_0000);
		send_coord(0, 0, 32'sh0001_0000, '0);
		send_coord(0, 1, -32'sd65536, COORD_MIN);
		send_coord(0, 1, COORD_MIN, COORD_MAX);
		send_coord(0, 0, COORD_MAX, -32'sd1);
		send_coord(0, 1, -32'sd1, 32'sd5);
		finish_phase();

		program_axis(0, MODE_REFLECT, -64'sd65536, 64'sd65536);
		program_axis(1, MODE_REPULSE, -64'sd131072, 64'sd131072);
		write_reg(REG_SPRING, CFG_DATA_W'({GAIN_W{1'b1}}));
		send_coord(1, 0, -32'sd65536, 32'sd7);
		send_coord(0, 0, 32'sd65536, 32'sd7);
		send_coord(0, 0, COORD_MIN, COORD_MIN);
		send_coord(0, 0, COORD_MAX, 32'sd100);
		send_coord(0, 0, 32'sh0001_8000, -32'sd5);
		send_coord(0, 1, 32'sd131072, '0);
		// max gain from far outside: velocity and the force total both clip
		send_coord(0, 1, COORD_MAX, '0);
		send_coord(0, 1, COORD_MIN, COORD_MAX);
		send_coord(0, 1, COORD_MAX, COORD_MAX);
		send_coord(1, 1, -32'sd196608, 32'sd3);
		finish_phase();

		program_axis(0, MODE_NONE, 64'sh7000_0000, COORD_LO);
		program_axis(1, MODE_WRAP, 64'sd256, 64'sd256);
		write_reg(REG_SPRING, '0);
		send_coord(0, 0, COORD_MAX, COORD_MIN);
		send_coord(0, 1, '0, 32'sd1);
		finish_phase();

		program_axis(0, MODE_WRAP, COORD_LO, COORD_HI);
		program_axis(1, MODE_REFLECT, 64'sh7000_0000, COORD_HI);
		send_coord(0, 0, COORD_MAX, 32'sd1);
		send_coord(0, 0, COORD_MIN, 32'sd1);
		send_coord(0, 1, COORD_MIN, 32'sd9);
		finish_phase();

		// zero gain: repulse changes nothing and adds nothing
		write_reg(REG_MODE_DIM1, CFG_DATA_W'(MODE_REPULSE));
		send_coord(0, 1, '0, 32'sd4);
		finish_phase();

		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 2 || ph == 5);
			program_random_box();
			run_random(100);
			finish_phase();
		end

		repeat (DIRECTED_DRAIN) @(posedge clk);
		$display("%0d coordinates: %0d wrapped, %0d reflected, %0d repulsed, %0d unchanged",
			sb.n_wrapped + sb.n_reflected + sb.n_repulsed + sb.n_unchanged,
			sb.n_wrapped, sb.n_reflected, sb.n_repulsed, sb.n_unchanged);
		$display("%0d register writes across 10 box settings, %0d mismatches",
			sb.n_writes, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
